@@ rtl/core/frac_pkg.sv @@
// Package for the fraction arithmetic unit: widths, command codes, FSM states.
// No dependencies.
package frac_pkg;
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int NUM_OUT_W = 48;
    localparam int DEN_OUT_W = 31;
    localparam int CMD_W = 2;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_MUL_ALT = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_GCD,
        ST_DIV_N,
        ST_DIV_D,
        ST_LCM_Q,
        ST_LCM_L,
        ST_SCALE_A,
        ST_SCALE_B,
        ST_MUL_A,
        ST_MUL_B,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage

@@ rtl/core/frac_if.sv @@
// Valid/ready channel interfaces for the fraction arithmetic unit.
// Depends on frac_pkg.
interface frac_in_if import frac_pkg::*; #(parameter int OW = OPERAND_WIDTH_DEF) ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic signed [OW-1:0] num_a;
    logic [OW-2:0]     den_a;
    logic signed [OW-1:0] num_b;
    logic [OW-2:0]     den_b;
    modport source (output valid, command, num_a, den_a, num_b, den_b, input ready);
    modport sink   (input valid, command, num_a, den_a, num_b, den_b, output ready);
endinterface

interface frac_out_if import frac_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [NUM_OUT_W-1:0] num_result;
    logic [DEN_OUT_W-1:0]        den_result;
    logic                        status;
    modport source (output valid, num_result, den_result, status, input ready);
    modport sink   (input valid, num_result, den_result, status, output ready);
endinterface

@@ rtl/core/frac_div.sv @@
// Shared restoring divider: one quotient bit per cycle, 64-bit operands.
// Depends on frac_pkg.
module frac_div import frac_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output t_div_ctl    o_ctl,
    output logic [63:0] o_quot,
    output logic [63:0] o_rem
);
    logic [63:0] r_q, n_q;
    logic [63:0] r_r, n_r;
    logic [63:0] r_d;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [64:0] w_sh;
    logic [64:0] w_diff;

    always_comb begin
        w_sh   = {r_r, r_q[63]};
        w_diff = w_sh - {1'b0, r_d};
        if (!w_diff[64]) begin
            n_r = w_diff[63:0];
            n_q = {r_q[62:0], 1'b1};
        end else begin
            n_r = w_sh[63:0];
            n_q = {r_q[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_ctl  = '{start: i_start, busy: r_busy, done: r_done};
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

@@ rtl/core/frac_seq.sv @@
// Sequencer: drives the shared divider and one multiplier through gcd, lcm,
// scaling and reduction. Depends on frac_pkg and frac_div.
module frac_seq import frac_pkg::*; #(
    parameter int OW = OPERAND_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [OW-1:0]      i_na,
    input  logic [OW-2:0]      i_da,
    input  logic [OW-1:0]      i_nb,
    input  logic [OW-2:0]      i_db,
    input  logic               i_take,
    output logic               o_idle,
    output logic               o_done,
    output logic [NUM_OUT_W-1:0] o_num,
    output logic [DEN_OUT_W-1:0] o_den,
    output logic               o_status
);
    localparam int PW = 2 * OW + 2;

    t_state r_state, n_state;
    logic [63:0] r_na, r_nb, r_da, r_db;
    logic [63:0] r_x, r_y;      // gcd operands
    logic [63:0] r_mag, r_d, r_g, r_l, r_t;
    logic        r_neg, r_err, r_add;
    logic        w_start;
    logic [63:0] w_dvd, w_dvs;
    t_div_ctl    w_dc;
    logic [63:0] w_q, w_r;
    logic [63:0] w_ma, w_mb, w_prod;
    logic signed [PW-1:0] w_prod_full;
    logic [63:0] r_q_l;

    frac_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_dividend(w_dvd), .i_divisor(w_dvs),
        .o_ctl(w_dc), .o_quot(w_q), .o_rem(w_r)
    );

    // every operand fits in OW+1 signed bits, so the product wraps like a 64-bit one
    assign w_prod_full = $signed(w_ma[OW:0]) * $signed(w_mb[OW:0]);
    assign w_prod      = 64'(w_prod_full);
    always_comb begin
        w_ma = r_na;
        w_mb = r_nb;
        unique case (r_state)
            ST_MUL_P:   begin w_ma = r_da;  w_mb = r_db; end
            ST_LCM_L:   begin w_ma = r_q_l; w_mb = r_db; end
            ST_MUL_A:   begin w_ma = r_na;  w_mb = r_t;  end
            ST_MUL_B:   begin w_ma = r_nb;  w_mb = r_t;  end
            default:    begin w_ma = r_na;  w_mb = r_nb; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        w_start = 1'b0;
        w_dvd   = r_x;
        w_dvs   = r_y;
        unique case (r_state)
            ST_IDLE:  if (i_go) n_state = ST_MUL_P;
            ST_MUL_P: begin
                if (r_err) n_state = ST_DONE;
                else if (r_add) n_state = ST_GCD;
                else n_state = ST_GCD;
            end
            ST_GCD: begin
                // hold while the operands load
                if (!r_t[1] && !w_dc.busy && !w_dc.done) begin
                    if (r_y == 64'd0) n_state = r_add ? ST_LCM_Q : ST_DIV_N;
                    else w_start = 1'b1;
                end
            end
            ST_DIV_N: begin
                w_dvd = r_mag; w_dvs = r_g;
                if (!w_dc.busy && !w_dc.done) w_start = 1'b1;
                else if (w_dc.done) n_state = ST_DIV_D;
            end
            ST_DIV_D: begin
                w_dvd = r_d; w_dvs = r_g;
                if (!w_dc.busy && !w_dc.done && !r_t[0]) w_start = 1'b1;
                else if (w_dc.done) n_state = ST_DONE;
            end
            ST_LCM_Q: begin
                w_dvd = r_da; w_dvs = r_g;
                if (!w_dc.busy && !w_dc.done && !r_t[0]) w_start = 1'b1;
                else if (w_dc.done) n_state = ST_LCM_L;
            end
            ST_LCM_L:   n_state = ST_SCALE_A;
            ST_SCALE_A: begin
                w_dvd = r_l; w_dvs = r_da;
                if (!w_dc.busy && !w_dc.done && !r_t[0]) w_start = 1'b1;
                else if (w_dc.done) n_state = ST_MUL_A;
            end
            ST_MUL_A:   n_state = ST_SCALE_B;
            ST_SCALE_B: begin
                w_dvd = r_l; w_dvs = r_db;
                if (!w_dc.busy && !w_dc.done && !r_t[0]) w_start = 1'b1;
                else if (w_dc.done) n_state = ST_MUL_B;
            end
            ST_MUL_B:   n_state = ST_DONE;
            ST_DONE:    if (i_take) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // r_t[0] marks "divide already launched" in the single-divide states other than ST_DIV_N
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t   <= '0;
            r_err <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: if (i_go) begin
                    r_na  <= {{(64-OW){i_na[OW-1]}}, i_na};
                    r_nb  <= (i_cmd == CMD_SUB) ?
                             64'd0 - {{(64-OW){i_nb[OW-1]}}, i_nb} :
                             {{(64-OW){i_nb[OW-1]}}, i_nb};
                    r_da  <= {{(65-OW){1'b0}}, i_da};
                    r_db  <= {{(65-OW){1'b0}}, i_db};
                    r_err <= (i_da == '0) || (i_db == '0);
                    r_add <= !i_cmd[1];
                    r_neg <= 1'b0;
                    r_t   <= '0;
                end
                ST_MUL_P: begin
                    r_d    <= w_prod;
                    if (r_add) begin
                        r_x <= r_da;
                        r_y <= r_db;
                    end else begin
                        r_neg <= 1'b0;
                    end
                    r_t <= 64'd2;
                end
                ST_GCD: begin
                    if (r_t[1]) begin
                        // load multiply operands for gcd once
                        r_t <= '0;
                        if (!r_add) begin
                            r_neg <= w_prod[63];
                            r_mag <= w_prod[63] ? 64'd0 - w_prod : w_prod;
                            r_x   <= w_prod[63] ? 64'd0 - w_prod : w_prod;
                            r_y   <= r_d;
                        end
                    end else if (w_dc.done) begin
                        r_x <= r_y;
                        r_y <= w_r;
                    end else if (!w_dc.busy && r_y == 64'd0) begin
                        r_g <= (r_x == 64'd0) ? 64'd1 : r_x;
                    end
                end
                ST_DIV_N: if (w_dc.done) r_mag <= w_q;
                ST_DIV_D: begin
                    if (w_start) r_t <= 64'd1;
                    if (w_dc.done) begin r_d <= w_q; r_t <= '0; end
                end
                ST_LCM_Q: begin
                    if (w_start) r_t <= 64'd1;
                    if (w_dc.done) begin r_q_l <= w_q; r_t <= '0; end
                end
                ST_LCM_L: r_l <= w_prod;
                ST_SCALE_A: begin
                    if (w_start) r_t <= 64'd1;
                    if (w_dc.done) r_t <= w_q;
                end
                ST_MUL_A: begin r_mag <= w_prod; r_t <= '0; end
                ST_SCALE_B: begin
                    if (w_start) r_t <= 64'd1;
                    if (w_dc.done) r_t <= w_q;
                end
                ST_MUL_B: begin r_mag <= r_mag + w_prod; r_d <= r_l; end
                default: ;
            endcase
        end
    end

    logic [63:0] w_num;
    assign w_num    = (!r_add && r_neg) ? 64'd0 - r_mag : r_mag;
    assign o_idle   = (r_state == ST_IDLE);
    assign o_done   = (r_state == ST_DONE);
    assign o_num    = r_err ? '0 : w_num[NUM_OUT_W-1:0];
    assign o_den    = r_err ? '0 : r_d[DEN_OUT_W-1:0];
    assign o_status = r_err;
endmodule

@@ rtl/core/fraction_arith_unit.sv @@
// Top level of the fraction arithmetic unit: channel ports around the sequencer.
// Depends on frac_pkg, frac_if, frac_seq.
//
// One item at a time. A zero denominator skips the divider and goes from the
// accept through ST_MUL_P to ST_DONE. Otherwise every Euclid step and every divide
// in the lcm, scaling and reduction uses the single shared restoring divider,
// so the number of Euclid steps on the operands sets how long an item takes.
// The result is held until taken; the next item is accepted after that.
module fraction_arith_unit import frac_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    frac_in_if.sink    in_ch,
    frac_out_if.source out_ch
);
    logic w_idle, w_done;

    frac_seq #(.OW(OPERAND_WIDTH)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_go(in_ch.valid && w_idle),
        .i_cmd(in_ch.command),
        .i_na(in_ch.num_a), .i_da(in_ch.den_a),
        .i_nb(in_ch.num_b), .i_db(in_ch.den_b),
        .i_take(out_ch.ready),
        .o_idle(w_idle), .o_done(w_done),
        .o_num(out_ch.num_result), .o_den(out_ch.den_result),
        .o_status(out_ch.status)
    );

    assign in_ch.ready  = w_idle;
    assign out_ch.valid = w_done;
endmodule
